>>> hdl/fsc_pkg.sv
package fsc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    localparam int NORM_W  = 18;
    localparam int COORD_W = 32;
    localparam int OFS_W   = 32;
    localparam int RAD_W   = 31;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = NORM_W + COORD_W;
    localparam int ACC_W   = 54;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic [OFS_W-1:0]  ofs;
    } t_plane;

    typedef struct packed {
        logic mul_en;
        logic acc_init;
        logic acc_add;
    } t_mac_ctl;

endpackage

>>> hdl/fsc_if.sv
interface fsc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  plane_index;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic signed [17:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0] sphere_radius;

    modport source (
        output valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

interface fsc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

>>> hdl/frustum_sphere_cull.sv
// Channel  Dir  Payload                                            Accept
// i_in     in   op, plane_index, normal_x/y/z, plane_offset,       valid && ready
//               center_x/y/z, sphere_radius
// o_out    out  verdict                                            valid && ready
//
// A load writes the plane table at the accepting edge.
// A test runs three multiply and three accumulate steps plus one compare per plane,
// all on one 18x32 multiplier.
// The input is not ready while a test runs; the verdict sits in an output register,
// and a new item is taken while it waits. A finished test stalls only if that
// register is still full. Reset clears every plane table entry to zero.
module frustum_sphere_cull (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsc_in_if.sink    i_in,
    fsc_out_if.source o_out
);

    fsc_pkg::t_state r_state, n_state;
    logic [fsc_pkg::PLANE_IDX_W-1:0] r_plane, n_plane;
    logic [1:0] r_term, n_term;
    logic r_outside, n_outside;
    logic r_touch, n_touch;
    logic r_out_valid, n_out_valid;
    fsc_pkg::t_verdict r_verdict, n_verdict;

    logic signed [fsc_pkg::COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [fsc_pkg::RAD_W-1:0] r_rad;

    logic accept;
    logic load_we;
    logic [31:0] load_slot;
    logic out_free;
    fsc_pkg::t_plane wdata, rdata;
    fsc_pkg::t_mac_ctl mac_ctl;
    logic signed [fsc_pkg::NORM_W-1:0]  coef;
    logic signed [fsc_pkg::COORD_W-1:0] coord;
    logic signed [fsc_pkg::ACC_W-1:0]   acc_init, acc, rad_q, sum_neg;

    assign accept    = i_in.valid && i_in.ready;
    assign load_slot = 32'(i_in.plane_index);
    assign load_we   = accept && (i_in.op == fsc_pkg::OP_LOAD)
                       && (load_slot < 32'(fsc_pkg::PLANE_COUNT));
    assign wdata     = '{nx: i_in.normal_x, ny: i_in.normal_y, nz: i_in.normal_z,
                         ofs: i_in.plane_offset};

    fsc_plane_tab u_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (load_we),
        .i_waddr (load_slot[fsc_pkg::PLANE_IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_plane),
        .o_rdata (rdata)
    );

    always_comb begin
        case (r_term)
            2'd0:    begin coef = $signed(rdata.nx); coord = r_cx; end
            2'd1:    begin coef = $signed(rdata.ny); coord = r_cy; end
            default: begin coef = $signed(rdata.nz); coord = r_cz; end
        endcase
    end

    // offset aligned to the product scale (Q.16)
    assign acc_init = fsc_pkg::ACC_W'($signed({rdata.ofs, {fsc_pkg::FRAC_W{1'b0}}}));
    assign rad_q    = fsc_pkg::ACC_W'({r_rad, {fsc_pkg::FRAC_W{1'b0}}});
    assign sum_neg  = acc + rad_q;

    fsc_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_coef  (coef),
        .i_coord (coord),
        .i_init  (acc_init),
        .o_acc   (acc)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == fsc_pkg::S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.verdict = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsc_pkg::S_IDLE;
            r_plane     <= '0;
            r_term      <= '0;
            r_outside   <= 1'b0;
            r_touch     <= 1'b0;
            r_out_valid <= 1'b0;
            r_verdict   <= fsc_pkg::VERDICT_INSIDE;
        end else begin
            r_state     <= n_state;
            r_plane     <= n_plane;
            r_term      <= n_term;
            r_outside   <= n_outside;
            r_touch     <= n_touch;
            r_out_valid <= n_out_valid;
            r_verdict   <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.op == fsc_pkg::OP_TEST)) begin
            r_cx  <= i_in.center_x;
            r_cy  <= i_in.center_y;
            r_cz  <= i_in.center_z;
            r_rad <= i_in.sphere_radius;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_plane     = r_plane;
        n_term      = r_term;
        n_outside   = r_outside;
        n_touch     = r_touch;
        n_out_valid = r_out_valid && !o_out.ready;
        n_verdict   = r_verdict;
        mac_ctl     = '0;
        case (r_state)
            fsc_pkg::S_IDLE: begin
                if (accept && (i_in.op == fsc_pkg::OP_TEST)) begin
                    n_state   = fsc_pkg::S_MUL;
                    n_plane   = '0;
                    n_term    = '0;
                    n_outside = 1'b0;
                    n_touch   = 1'b0;
                end
            end
            fsc_pkg::S_MUL: begin
                mac_ctl.mul_en   = 1'b1;
                mac_ctl.acc_init = (r_term == 2'd0);
                n_state          = fsc_pkg::S_ACC;
            end
            fsc_pkg::S_ACC: begin
                mac_ctl.acc_add = 1'b1;
                if (r_term == 2'd2) begin
                    n_state = fsc_pkg::S_CMP;
                end else begin
                    n_term  = r_term + 2'd1;
                    n_state = fsc_pkg::S_MUL;
                end
            end
            fsc_pkg::S_CMP: begin
                // dist < -r  <=>  dist + r < 0
                if (sum_neg < 0) begin
                    n_outside = 1'b1;
                end else if (acc < rad_q) begin
                    n_touch = 1'b1;
                end
                n_term = '0;
                if (r_plane == fsc_pkg::PLANE_IDX_W'(fsc_pkg::PLANE_COUNT - 1)) begin
                    n_state = fsc_pkg::S_DONE;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = fsc_pkg::S_MUL;
                end
            end
            fsc_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_outside) begin
                        n_verdict = fsc_pkg::VERDICT_OUTSIDE;
                    end else if (r_touch) begin
                        n_verdict = fsc_pkg::VERDICT_INTERSECT;
                    end else begin
                        n_verdict = fsc_pkg::VERDICT_INSIDE;
                    end
                    n_state = fsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fsc_plane_tab.sv
module fsc_plane_tab (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [fsc_pkg::PLANE_IDX_W-1:0]   i_waddr,
    input  fsc_pkg::t_plane                   i_wdata,
    input  logic [fsc_pkg::PLANE_IDX_W-1:0]   i_raddr,
    output fsc_pkg::t_plane                   o_rdata
);

    fsc_pkg::t_plane r_tab [fsc_pkg::PLANE_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsc_pkg::PLANE_COUNT; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_we) begin
            r_tab[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_tab[i_raddr];

endmodule

>>> hdl/fsc_mac.sv
module fsc_mac (
    input  logic                               i_clk,
    input  fsc_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [fsc_pkg::NORM_W-1:0]  i_coef,
    input  logic signed [fsc_pkg::COORD_W-1:0] i_coord,
    input  logic signed [fsc_pkg::ACC_W-1:0]   i_init,
    output logic signed [fsc_pkg::ACC_W-1:0]   o_acc
);

    logic signed [fsc_pkg::PROD_W-1:0] r_prod;
    logic signed [fsc_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_coord;
        end
        if (i_ctl.acc_init) begin
            r_acc <= i_init;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + fsc_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hdl/fsc_checker.sv
module fsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_op,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_verdict
);

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_verdict == fsc_pkg::VERDICT_INSIDE
                         || i_out_verdict == fsc_pkg::VERDICT_INTERSECT
                         || i_out_verdict == fsc_pkg::VERDICT_OUTSIDE))
        else $error("verdict code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_verdict)))
        else $error("stalled verdict dropped or changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not idle after reset");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_op == fsc_pkg::OP_TEST) |=> !i_in_ready)
        else $error("item taken during a test");

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.op),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_verdict (o_out.verdict)
);
